FILE: rtl/pbpt_pkg.sv
// Shared types and constants for the priority beep pattern timer.
package pbpt_pkg;

	localparam int unsigned OPCODE_W = 3;
	localparam int unsigned CHAN_W   = 2;
	localparam int unsigned COUNT_W  = 8;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned SETUP_W  = 40;
	localparam int unsigned LEN_W    = 16;
	localparam int unsigned PHASE_W  = 17;
	localparam int unsigned PRIO_W   = 8;
	localparam int unsigned SETUP_REGS = 4;

	localparam logic [OPCODE_W-1:0] OP_TICK     = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_START    = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_CONT_ON  = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_CONT_OFF = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_MUTE     = 3'd4;

	typedef struct packed {
		logic [PRIO_W-1:0] prio;
		logic [LEN_W-1:0]  off_len;
		logic [LEN_W-1:0]  on_len;
	} setup_t;

endpackage

FILE: rtl/priority_beep_pattern_timer.sv
// Top level of the priority beep pattern timer.
// An accepted command enters an input register and is applied to the channel state from
// there; a tick then loads its drive level into the result register, from which it is shown.
// One command per cycle is sustained; a tick only
// waits while a previous result is held by a stalled output.
// The asynchronous reset clears setups, channel state and both valid flags.
module priority_beep_pattern_timer import pbpt_pkg::*; #(
	parameter int unsigned CHANNELS = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [OPCODE_W-1:0]  opcode,
	input  logic [CHAN_W-1:0]    channel,
	input  logic [COUNT_W-1:0]   repeat_count,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 drive_level,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SETUP_W-1:0]   cfg_data
);

	setup_t               setup_q [CHANNELS];
	logic [COUNT_W-1:0]   rep_q   [CHANNELS];
	logic [PHASE_W-1:0]   phase_q [CHANNELS];
	logic                 cont_q  [CHANNELS];

	logic [COUNT_W-1:0]   rep_n   [CHANNELS];
	logic [PHASE_W-1:0]   phase_n [CHANNELS];
	logic                 cont_n  [CHANNELS];
	logic [COUNT_W-1:0]   rep_t   [CHANNELS];
	logic [PHASE_W-1:0]   phase_t [CHANNELS];
	logic [PHASE_W-1:0]   span    [CHANNELS];
	logic                 active  [CHANNELS];
	logic                 lvl     [CHANNELS];

	logic                 valid_s1;
	logic [OPCODE_W-1:0]  opcode_s1;
	logic [CHAN_W-1:0]    channel_s1;
	logic [COUNT_W-1:0]   count_s1;

	logic                 out_valid_q;
	logic                 drive_q;

	logic                 is_tick;
	logic                 out_free;
	logic                 s1_go;
	logic                 tick_go;
	logic                 found;
	logic [PRIO_W-1:0]    best;
	logic                 level;

	assign cfg_ready   = 1'b1;
	assign out_valid   = out_valid_q;
	assign drive_level = drive_q;

	assign is_tick  = (opcode_s1 == OP_TICK);
	assign out_free = !out_valid_q || !out_stall;
	assign s1_go    = valid_s1 && (!is_tick || out_free);
	assign tick_go  = s1_go && is_tick;
	assign in_stall = valid_s1 && !s1_go;

	always_comb begin
		for (int k = 0; k < CHANNELS; k++) begin
			active[k]  = (rep_q[k] != '0) || cont_q[k];
			span[k]    = {1'b0, setup_q[k].on_len} + {1'b0, setup_q[k].off_len};
			rep_t[k]   = rep_q[k];
			phase_t[k] = phase_q[k];
			if (active[k]) begin
				if (phase_q[k] < span[k]) begin
					phase_t[k] = phase_q[k] + 1'b1;
				end else begin
					phase_t[k] = '0;
					if (rep_q[k] != '0) begin
						rep_t[k] = rep_q[k] - 1'b1;
					end
				end
			end
			lvl[k] = (phase_t[k] <= {1'b0, setup_q[k].on_len}) &&
				((rep_t[k] != '0) || cont_q[k]);
		end
	end

	always_comb begin
		found = 1'b0;
		best  = '0;
		level = 1'b0;
		for (int k = 0; k < CHANNELS; k++) begin
			if (active[k] && (!found || setup_q[k].prio > best)) begin
				found = 1'b1;
				best  = setup_q[k].prio;
				level = lvl[k];
			end
		end
	end

	always_comb begin
		for (int k = 0; k < CHANNELS; k++) begin
			rep_n[k]   = rep_q[k];
			phase_n[k] = phase_q[k];
			cont_n[k]  = cont_q[k];
			if (s1_go) begin
				unique case (opcode_s1)
					OP_TICK: begin
						rep_n[k]   = rep_t[k];
						phase_n[k] = phase_t[k];
					end
					OP_START: begin
						if (32'(channel_s1) == k) begin
							phase_n[k] = '0;
							rep_n[k]   = count_s1;
						end
					end
					OP_CONT_ON: begin
						if (32'(channel_s1) == k) begin
							rep_n[k]  = '0;
							cont_n[k] = 1'b1;
						end
					end
					OP_CONT_OFF: begin
						if (32'(channel_s1) == k) begin
							cont_n[k] = 1'b0;
						end
					end
					OP_MUTE: begin
						rep_n[k]   = '0;
						phase_n[k] = '0;
						cont_n[k]  = 1'b0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < CHANNELS; k++) begin
				setup_q[k] <= '0;
				rep_q[k]   <= '0;
				phase_q[k] <= '0;
				cont_q[k]  <= 1'b0;
			end
		end else begin
			for (int k = 0; k < CHANNELS; k++) begin
				rep_q[k]   <= rep_n[k];
				phase_q[k] <= phase_n[k];
				cont_q[k]  <= cont_n[k];
				if (cfg_valid && cfg_ready && (32'(cfg_index) == k) && (k < SETUP_REGS)) begin
					setup_q[k] <= setup_t'(cfg_data);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (out_free) begin
				out_valid_q <= tick_go;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			opcode_s1  <= opcode;
			channel_s1 <= channel;
			count_s1   <= repeat_count;
		end
		if (tick_go) begin
			drive_q <= level;
		end
	end

endmodule

FILE: rtl/pbpt_checker.sv
// Port-level checker for the priority beep pattern timer, with its bind.
module pbpt_checker import pbpt_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic [OPCODE_W-1:0] opcode,
	input logic                out_valid,
	input logic                out_stall,
	input logic                drive_level
);

	logic in_acc;
	assign in_acc = in_valid && !in_stall;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(drive_level))
		else $error("Stalled result transaction changed or vanished.");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("Input stalled while the output was free.");

	a_tick_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && opcode == OP_TICK) ##1 !out_valid |=> out_valid)
		else $error("Tick transaction gave no result on time.");

	a_mute_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && opcode == OP_MUTE) ##1 (in_acc && opcode == OP_TICK) ##1 !out_valid
		|=> out_valid && !drive_level)
		else $error("Tick right after mute was not silent.");

endmodule

bind priority_beep_pattern_timer pbpt_checker u_pbpt_checker (.*);
